// ===== rtl/pxc_pkg.sv =====
// Shared types and constants of the pixel compositor.
package pxc_pkg;

  localparam int PIX_W  = 32;
  localparam int CH_W   = 8;
  localparam int ADDR_W = 4;

  localparam logic [PIX_W-1:0] RB_MASK  = 32'h00FF_00FF;
  localparam logic [PIX_W-1:0] G_MASK   = 32'h0000_FF00;
  localparam logic [PIX_W-1:0] ALPHA_FF = 32'hFF00_0000;
  localparam logic [PIX_W-1:0] WHITE    = 32'hFFFF_FFFF;
  localparam logic [CH_W-1:0]  CH_MAX   = 8'hFF;
  localparam logic [CH_W-1:0]  CH_ZERO  = 8'h00;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_SOURCE_KIND = 2'd0;
  localparam logic [1:0] REG_TINT_ENABLE = 2'd1;
  localparam logic [1:0] REG_TINT_COLOR  = 2'd2;

  // Source kinds.
  localparam logic [1:0] KIND_OPAQUE = 2'd0;
  localparam logic [1:0] KIND_ONEBIT = 2'd1;
  localparam logic [1:0] KIND_BLEND  = 2'd2;
  localparam logic [1:0] KIND_FONT   = 2'd3;

  typedef enum logic [1:0] {
    PATH_COPY = 2'd0,
    PATH_MIX  = 2'd1,
    PATH_MUL  = 2'd2
  } path_t;

  typedef struct packed {
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;
  } in_word_t;

  typedef struct packed {
    logic             write_enable;
    logic [PIX_W-1:0] out_pixel;
  } out_word_t;

endpackage

// ===== rtl/pixel_compositor.sv =====
// Pixel compositor: four-stage ARGB8888 blend pipeline with an APB register port.
//
// Usage: each input word carries one source pixel and the destination pixel
// it lands on; each output word carries a write enable and the new pixel
// (the unchanged destination when the write enable is low). Both channels
// use valid/ready. The registers source_kind, tint_enable and tint_color sit
// at byte addresses 0, 4 and 8 of the APB port; the user must write them only
// while the pipeline is empty, as the block itself does not enforce it.
//
// A word accepted at the input passes the stage 1, 2 and 3 registers and the output
// register before it appears on out_valid. Throughput is one word per cycle while
// out_ready is high; the limit is the chain of multipliers in stages 1 to 3 (channel
// products, then the 32x8 mix products, then the signed tint blend products), each registered.
//
// Reset clears every stage's valid bit and loads the register defaults
// (opaque copy, no tint, tint color all ones). When the receiver holds
// out_ready low, words pile up in the stages behind the output register and
// in_ready drops only once every stage is full; nothing is lost or repeated.
module pixel_compositor
  import pxc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [PIX_W-1:0]      pwdata,
  output logic [PIX_W-1:0]      prdata,
  output logic                  pready
);

  // ---------------- configuration registers ----------------
  logic [1:0]       source_kind_r;
  logic             tint_enable_r;
  logic [PIX_W-1:0] tint_color_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_kind_r <= KIND_OPAQUE;
      tint_enable_r <= 1'b0;
      tint_color_r  <= WHITE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SOURCE_KIND: source_kind_r <= pwdata[1:0];
        REG_TINT_ENABLE: tint_enable_r <= pwdata[0];
        REG_TINT_COLOR:  tint_color_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SOURCE_KIND: prdata = {30'd0, source_kind_r};
      REG_TINT_ENABLE: prdata = {31'd0, tint_enable_r};
      REG_TINT_COLOR:  prdata = tint_color_r;
      default:         prdata = '0;
    endcase
  end

  // ---------------- stage handshake ----------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_en, s2_en, s3_en, out_en;

  assign out_en   = !out_valid_r || out_ready;
  assign s3_en    = !s3_valid_r || out_en;
  assign s2_en    = !s2_valid_r || s3_en;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en)  s1_valid_r  <= in_valid;
      if (s2_en)  s2_valid_r  <= s1_valid_r;
      if (s3_en)  s3_valid_r  <= s2_valid_r;
      if (out_en) out_valid_r <= s3_valid_r;
    end
  end

  // ---------------- stage 1: decode and channel products ----------------
  logic [PIX_W-1:0] src, dst;
  logic [CH_W-1:0]  sa, ta, inv_sa;
  path_t            path_nxt;
  logic             we_nxt;
  logic [PIX_W-1:0] px_nxt, col, rbdiff_nxt, gdiff_nxt;
  logic [2*CH_W-1:0] sat_prod;
  logic [2:0][2*CH_W-1:0] ch_prod;

  assign src    = in_data.src_pixel;
  assign dst    = in_data.dst_pixel;
  assign sa     = src[31:24];
  assign ta     = tint_color_r[31:24];
  assign inv_sa = CH_MAX - sa;
  assign col    = tint_enable_r ? tint_color_r : src;

  always_comb begin
    path_nxt = PATH_COPY;
    we_nxt   = 1'b1;
    px_nxt   = dst;
    if (tint_enable_r) begin
      if (sa == CH_ZERO) begin
        we_nxt = 1'b0;
      end else if (source_kind_r == KIND_FONT && ta == CH_MAX) begin
        // Black text onto a white destination is produced directly.
        if (tint_color_r == ALPHA_FF && dst == WHITE) begin
          px_nxt = {CH_MAX, inv_sa, inv_sa, inv_sa};
        end else begin
          path_nxt = PATH_MIX;
        end
      end else begin
        path_nxt = PATH_MUL;
      end
    end else if (source_kind_r == KIND_OPAQUE) begin
      px_nxt = src;
    end else if (source_kind_r == KIND_ONEBIT) begin
      if (sa == CH_ZERO) we_nxt = 1'b0;
      else px_nxt = src;
    end else begin
      if (sa == CH_MAX) px_nxt = src;
      else if (sa == CH_ZERO) we_nxt = 1'b0;
      else path_nxt = PATH_MIX;
    end
  end

  assign rbdiff_nxt = (col & RB_MASK) - (dst & RB_MASK);
  assign gdiff_nxt  = (col & G_MASK) - (dst & G_MASK);
  assign sat_prod   = {8'd0, sa} * {8'd0, ta};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch_prod[i] = {8'd0, src[i*CH_W +: CH_W]} * {8'd0, tint_color_r[i*CH_W +: CH_W]};
    end
  end

  path_t            s1_path_r;
  logic             s1_we_r;
  logic [PIX_W-1:0] s1_px_r, s1_dst_r, s1_rbdiff_r, s1_gdiff_r;
  logic [CH_W-1:0]  s1_ma_r, s1_sa_r;
  logic [2:0][CH_W-1:0] s1_p_r;

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_path_r   <= path_nxt;
      s1_we_r     <= we_nxt;
      s1_px_r     <= px_nxt;
      s1_dst_r    <= dst;
      s1_rbdiff_r <= rbdiff_nxt;
      s1_gdiff_r  <= gdiff_nxt;
      s1_ma_r     <= sa;
      s1_sa_r     <= sat_prod[15:8];
      for (int i = 0; i < 3; i++) s1_p_r[i] <= ch_prod[i][15:8];
    end
  end

  // ---------------- stage 2: mix products and tint differences ----------------
  logic [PIX_W-1:0] rbprod_nxt, gprod_nxt;
  logic [CH_W:0]    a_nxt;
  logic [2:0][CH_W:0] diff_nxt;
  logic [2:0][CH_W-1:0] c_val;

  assign rbprod_nxt = s1_rbdiff_r * {24'd0, s1_ma_r};
  assign gprod_nxt  = s1_gdiff_r * {24'd0, s1_ma_r};
  // Alpha gets +2 when the product is 128 or more, reaching 256 at most.
  assign a_nxt = {1'b0, s1_sa_r} + {7'd0, s1_sa_r[7], 1'b0};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_val[i]    = s1_p_r[i] + {7'd0, s1_p_r[i][7]};
      diff_nxt[i] = {1'b0, c_val[i]} - {1'b0, s1_dst_r[i*CH_W +: CH_W]};
    end
  end

  path_t            s2_path_r;
  logic             s2_we_r;
  logic [PIX_W-1:0] s2_px_r, s2_dst_r, s2_rbprod_r, s2_gprod_r;
  logic [CH_W:0]    s2_a_r;
  logic [2:0][CH_W:0] s2_diff_r;

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_path_r   <= s1_path_r;
      s2_we_r     <= s1_we_r;
      s2_px_r     <= s1_px_r;
      s2_dst_r    <= s1_dst_r;
      s2_rbprod_r <= rbprod_nxt;
      s2_gprod_r  <= gprod_nxt;
      s2_a_r      <= a_nxt;
      s2_diff_r   <= diff_nxt;
    end
  end

  // ---------------- stage 3: mix sum and signed tint products ----------------
  logic [PIX_W-1:0] rb_sum, g_sum, mixpx_nxt;
  logic signed [2:0][18:0] mprod_nxt;

  assign rb_sum    = (s2_dst_r & RB_MASK) + (s2_rbprod_r >> 8);
  assign g_sum     = (s2_dst_r & G_MASK) + (s2_gprod_r >> 8);
  assign mixpx_nxt = (rb_sum & RB_MASK) | (g_sum & G_MASK) | ALPHA_FF;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mprod_nxt[i] = $signed({{10{s2_diff_r[i][CH_W]}}, s2_diff_r[i]})
                   * $signed({10'd0, s2_a_r});
    end
  end

  path_t            s3_path_r;
  logic             s3_we_r;
  logic [PIX_W-1:0] s3_px_r, s3_dst_r, s3_mixpx_r;
  logic [2:0][18:0] s3_mprod_r;

  always_ff @(posedge clk) begin
    if (s3_en) begin
      s3_path_r  <= s2_path_r;
      s3_we_r    <= s2_we_r;
      s3_px_r    <= s2_px_r;
      s3_dst_r   <= s2_dst_r;
      s3_mixpx_r <= mixpx_nxt;
      s3_mprod_r <= mprod_nxt;
    end
  end

  // ---------------- stage 4: channel sums and output select ----------------
  // Bits 15:8 of the signed product are the floor of product/256, modulo 256.
  logic [2:0][CH_W-1:0] ch_out;
  out_word_t            out_data_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ch_out[i] = s3_dst_r[i*CH_W +: CH_W] + s3_mprod_r[i][15:8];
    end
  end

  always_comb begin
    out_data_nxt.write_enable = s3_we_r;
    case (s3_path_r)
      PATH_COPY: out_data_nxt.out_pixel = s3_px_r;
      PATH_MIX:  out_data_nxt.out_pixel = s3_mixpx_r;
      PATH_MUL:  out_data_nxt.out_pixel = {CH_MAX, ch_out[2], ch_out[1], ch_out[0]};
      default:   out_data_nxt.out_pixel = s3_px_r;
    endcase
  end

  out_word_t out_data_r;

  always_ff @(posedge clk) begin
    if (out_en) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== tb/sv/pixel_compositor_test.sv =====
// Self-checking testbench for the pixel compositor: random bursts, stalls and register phases.
module pixel_compositor_test;
  import pxc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Address slot with no register behind it; writes there must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [PIX_W-1:0] pwdata = '0;
  logic [PIX_W-1:0] prdata;
  logic pready;

  // Shadow copy of the block's registers, updated on each completed write.
  logic [1:0] kind_q = KIND_OPAQUE;
  logic tint_en_q = 1'b0;
  logic [PIX_W-1:0] tint_q = WHITE;

  in_word_t pixel_pairs[$];
  out_word_t pixel_results[$];
  int mismatches = 0;

  pixel_compositor u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Packed red/blue and green mix, all in 32-bit wraparound arithmetic.
  function automatic logic [31:0] mix_pixel(logic [31:0] dst, logic [31:0] col,
                                            logic [31:0] a);
    logic [31:0] rbd, gd, rb, g, t;
    rbd = dst & RB_MASK;
    t = (col & RB_MASK) - rbd;
    t = t * a;
    rb = rbd + (t >> 8);
    gd = dst & G_MASK;
    t = (col & G_MASK) - gd;
    t = t * a;
    g = gd + (t >> 8);
    return (rb & RB_MASK) + (g & G_MASK) + ALPHA_FF;
  endfunction

  function automatic logic [31:0] tint_multiply(logic [31:0] dst, logic [31:0] src,
                                                logic [31:0] tint);
    logic [15:0] sa, p;
    logic [8:0] a, c;
    logic [7:0] d;
    logic [31:0] res;
    int diff, q;
    sa = ({8'd0, src[31:24]} * {8'd0, tint[31:24]}) >> 8;
    a = 9'(sa + ((sa >> 6) & 16'd2));
    res = ALPHA_FF;
    for (int ch = 0; ch < 3; ch++) begin
      p = ({8'd0, src[ch*8 +: 8]} * {8'd0, tint[ch*8 +: 8]}) >> 8;
      c = 9'(p + (p >> 7));
      d = dst[ch*8 +: 8];
      diff = int'(c) - int'(d);
      // Arithmetic shift of the signed product rounds toward minus infinity.
      q = (diff * int'(a)) >>> 8;
      res[ch*8 +: 8] = d + q[7:0];
    end
    return res;
  endfunction

  function automatic out_word_t composite(in_word_t w);
    out_word_t r;
    logic [7:0] sa;
    sa = w.src_pixel[31:24];
    r.write_enable = 1'b1;
    r.out_pixel = w.dst_pixel;
    if (tint_en_q) begin
      if (sa == CH_ZERO) begin
        r.write_enable = 1'b0;
      end else if (kind_q == KIND_FONT && tint_q[31:24] == CH_MAX) begin
        if (tint_q == ALPHA_FF && w.dst_pixel == WHITE) begin
          r.out_pixel = 32'h0001_0101 * (32'd255 - 32'(sa)) + ALPHA_FF;
        end else begin
          r.out_pixel = mix_pixel(w.dst_pixel, tint_q, 32'(sa));
        end
      end else begin
        r.out_pixel = tint_multiply(w.dst_pixel, w.src_pixel, tint_q);
      end
    end else if (kind_q == KIND_OPAQUE) begin
      r.out_pixel = w.src_pixel;
    end else if (kind_q == KIND_ONEBIT) begin
      if (sa == CH_ZERO) r.write_enable = 1'b0;
      else r.out_pixel = w.src_pixel;
    end else begin
      if (sa == CH_MAX) r.out_pixel = w.src_pixel;
      else if (sa == CH_ZERO) r.write_enable = 1'b0;
      else r.out_pixel = mix_pixel(w.dst_pixel, w.src_pixel, 32'(sa));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_SOURCE_KIND: kind_q <= pwdata[1:0];
        REG_TINT_ENABLE: tint_en_q <= pwdata[0];
        REG_TINT_COLOR:  tint_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 1;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pixel_results.push_back(composite(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pixel_pairs.size() > 0) begin
          in_data <= pixel_pairs.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 32);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word and stalls on a pattern that changes now and then.
  int words_seen = 0;
  int hold_left = 0;
  int holds_done = 0;
  int stall_mode = 0;
  int rx_cycle = 0;
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_results.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual we=%0b pixel=%h",
                   $time, out_data.write_enable, out_data.out_pixel);
          mismatches++;
        end else begin
          want = pixel_results.pop_front();
          if (out_data.write_enable !== want.write_enable) begin
            $display("%0t: write_enable: expected %0b, actual %0b",
                     $time, want.write_enable, out_data.write_enable);
            mismatches++;
          end
          if (out_data.out_pixel !== want.out_pixel) begin
            $display("%0t: out_pixel: expected %h, actual %h",
                     $time, want.out_pixel, out_data.out_pixel);
            mismatches++;
          end
        end
        words_seen++;
      end
      // Long hold-offs start while plenty of words wait, so the pipeline fills
      // and in_ready drops.
      if (hold_left == 0 && holds_done < 2 && words_seen >= 300 * (holds_done + 1) &&
          pixel_pairs.size() >= 6) begin
        hold_left = 120;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 4) != 3;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      rx_cycle++;
      if (rx_cycle % 97 == 0) stall_mode = $urandom_range(0, 3);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pixel_pairs.size() != 0 || in_valid || pixel_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic reconfigure(input logic [1:0] kind, input logic en,
                             input logic [31:0] tint);
    drain();
    reg_write(REG_SOURCE_KIND, 32'(kind));
    reg_write(REG_TINT_ENABLE, 32'(en));
    reg_write(REG_TINT_COLOR, tint);
  endtask

  initial begin
    int sent;
    int n;
    logic [1:0] kind;
    logic en;
    logic [31:0] tint, src, dst;
    sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: opaque copy writes even a fully transparent source.
    pixel_pairs.push_back({32'h00AB_CDEF, 32'h1234_5678});
    pixel_pairs.push_back({32'hFFFF_FFFF, 32'h0000_0000});
    pixel_pairs.push_back({32'h8000_0000, WHITE});
    reconfigure(KIND_ONEBIT, 1'b0, WHITE);
    pixel_pairs.push_back({32'h00FF_FFFF, 32'h5555_AAAA});
    pixel_pairs.push_back({32'h0100_0000, WHITE});
    reconfigure(KIND_BLEND, 1'b0, WHITE);
    pixel_pairs.push_back({32'h00FF_FFFF, 32'h1234_5678});
    pixel_pairs.push_back({32'hFF12_3456, 32'h0000_0000});
    pixel_pairs.push_back({32'h80FF_00FF, 32'h0000_FF00});
    pixel_pairs.push_back({32'h0100_0000, WHITE});
    reconfigure(KIND_FONT, 1'b0, WHITE);
    pixel_pairs.push_back({32'h40FF_FFFF, 32'h0000_0000});
    // Black text onto white, plus the plain font mix around it.
    reconfigure(KIND_FONT, 1'b1, ALPHA_FF);
    pixel_pairs.push_back({32'h8000_0000, WHITE});
    pixel_pairs.push_back({32'hFF00_0000, WHITE});
    pixel_pairs.push_back({32'h0100_0000, WHITE});
    pixel_pairs.push_back({32'h80FF_FFFF, 32'hFF80_8080});
    pixel_pairs.push_back({32'h0000_0000, WHITE});
    // A write to the unused slot must leave the tint alone.
    reconfigure(KIND_FONT, 1'b1, 32'hFF12_3456);
    reg_write(REG_UNUSED, 32'h0000_0000);
    pixel_pairs.push_back({32'hC000_0000, 32'h00FE_DCBA});
    pixel_pairs.push_back({32'hFFFF_FFFF, 32'h0000_0000});
    reconfigure(KIND_FONT, 1'b1, 32'h80FF_FFFF);
    pixel_pairs.push_back({32'hFFFF_FFFF, 32'h0000_0000});
    pixel_pairs.push_back({32'h8080_8080, WHITE});
    reconfigure(KIND_OPAQUE, 1'b1, WHITE);
    pixel_pairs.push_back({32'hFFFF_FFFF, 32'h0000_0000});
    pixel_pairs.push_back({32'hFF00_0000, WHITE});
    reconfigure(KIND_BLEND, 1'b1, 32'h0000_0000);
    pixel_pairs.push_back({32'hFFFF_FFFF, WHITE});
    pixel_pairs.push_back({32'h7F12_3456, 32'hFEDC_BA98});

    while (sent < RANDOM_WORDS) begin
      kind = 2'($urandom_range(0, 3));
      en = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 5))
        0: tint = ALPHA_FF;
        1: tint = WHITE;
        2: tint = 32'h0000_0000;
        3: tint = {CH_MAX, 24'($urandom)};
        default: tint = $urandom;
      endcase
      reconfigure(kind, en, tint);
      n = $urandom_range(10, 50);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: src = {CH_ZERO, 24'($urandom)};
          1: src = {CH_MAX, 24'($urandom)};
          2: src = {8'h01, 24'($urandom)};
          default: src = $urandom;
        endcase
        case ($urandom_range(0, 7))
          0: dst = WHITE;
          1: dst = 32'h0000_0000;
          default: dst = $urandom;
        endcase
        pixel_pairs.push_back({src, dst});
      end
      sent += n;
    end

    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== pixel_compositor.f =====
rtl/pxc_pkg.sv
rtl/pixel_compositor.sv
tb/sv/pixel_compositor_test.sv
